// File: design/edf_pkg.sv
// Shared constants and command codes for the EDF tick scheduler.
package edf_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int JOB_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam logic [3:0] STACK_STARTED_RST = 4'd10;
    localparam logic [3:0] STACK_WAITING_RST = 4'd3;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] REG_NUM_TASKS     = 2'd0;
    localparam logic [1:0] REG_STACK_STARTED = 2'd1;
    localparam logic [1:0] REG_STACK_WAITING = 2'd2;

endpackage

// File: design/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler: task table, job slots, sequencer.
// Load and clear transactions are applied on acceptance. A tick walks n = min(num_tasks, MAX_TASKS)
// release checks on one shared restoring mod unit of DW = max(TIME_BITS,16) bits, then a
// selection scan over all job slots and, unless idle, a stack summing scan over all slots.
// The block is ready for the next transaction in the same cycle as the result turns valid;
// a stalled result holds the block busy.
// Reset: task table to phase 0, period 1, deadline 0, exec 1; no valid jobs,
// time 0, worst 0, num_tasks 0, stack_started 10, stack_waiting 3.
module edf_tick_scheduler
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int JOB_SLOTS = JOB_SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // task_index[2:0], release_offset[18:3], release_period[34:19],
    // relative_deadline[50:35], exec_ticks[66:51], zero fill
    input  logic [71:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tick_time[15:0], idle[16], running_task[19:17], stack_now[27:20],
    // stack_worst[35:28], slot_overflow[36], zero fill
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int KW = $clog2(MAX_TASKS + 1);
    localparam int SW = $clog2(JOB_SLOTS);
    localparam int IW = $clog2(JOB_SLOTS + 1);
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_REL, ST_DIV, ST_SEL, ST_DEC, ST_SUM, ST_FIN
    } state_t;

    state_t state_reg;

    logic [3:0] num_tasks_reg, stack_started_reg, stack_waiting_reg;

    logic [15:0] task_phase_reg    [MAX_TASKS];
    logic [15:0] task_period_reg   [MAX_TASKS];
    logic [15:0] task_deadline_reg [MAX_TASKS];
    logic [15:0] task_exec_reg     [MAX_TASKS];

    logic [JOB_SLOTS-1:0] job_valid_reg;
    logic [TW-1:0]        job_task_reg     [JOB_SLOTS];
    logic [TIME_BITS:0]   job_dl_reg       [JOB_SLOTS];
    logic [TIME_BITS-1:0] job_rel_reg      [JOB_SLOTS];
    logic [15:0]          job_left_reg     [JOB_SLOTS];

    logic [TIME_BITS-1:0] time_reg;
    logic [7:0]           worst_reg;
    logic [7:0]           sum_reg;
    logic                 ovf_reg;
    logic                 found_reg;
    logic [SW-1:0]        sel_reg;
    logic [TIME_BITS:0]   best_dl_reg;
    logic [TIME_BITS-1:0] best_rel_reg;
    logic [TW-1:0]        best_task_reg;
    logic [KW-1:0]        k_reg;
    logic [IW-1:0]        i_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW-1:0]        dvd_reg;
    logic [15:0]          rem_reg;

    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    // input fields
    logic [1:0]  command;
    logic [2:0]  task_index;
    logic [15:0] release_offset, release_period, relative_deadline, exec_ticks;
    assign command           = s_axis_tuser;
    assign task_index        = s_axis_tdata[2:0];
    assign release_offset    = s_axis_tdata[18:3];
    assign release_period    = s_axis_tdata[34:19];
    assign relative_deadline = s_axis_tdata[50:35];
    assign exec_ticks        = s_axis_tdata[66:51];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign pready        = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_TASKS:     prdata = {28'd0, num_tasks_reg};
            REG_STACK_STARTED: prdata = {28'd0, stack_started_reg};
            REG_STACK_WAITING: prdata = {28'd0, stack_waiting_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // effective task count
    logic [KW-1:0] n_eff;
    assign n_eff = (32'(num_tasks_reg) > MAX_TASKS) ? KW'(MAX_TASKS) : KW'(num_tasks_reg);

    logic [TW-1:0] k_idx;
    logic [SW-1:0] i_idx;
    assign k_idx = k_reg[TW-1:0];
    assign i_idx = i_reg[SW-1:0];

    // distance between time and phase; congruence holds when it divides evenly
    logic [DW-1:0] t_ext, ph_ext, phase_gap;
    assign t_ext     = DW'(time_reg);
    assign ph_ext    = DW'(task_phase_reg[k_idx]);
    assign phase_gap = (t_ext >= ph_ext) ? (t_ext - ph_ext) : (ph_ext - t_ext);

    // one restoring step of the mod unit
    logic [16:0] rem_sh, rem_sub;
    logic [15:0] rem_new;
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, task_period_reg[k_idx]};
    assign rem_new = (rem_sh >= {1'b0, task_period_reg[k_idx]}) ? rem_sub[15:0] : rem_sh[15:0];

    // lowest free slot
    logic          free_any;
    logic [SW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int s = JOB_SLOTS - 1; s >= 0; s--)
        begin
            if (!job_valid_reg[s])
            begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    logic [DW:0] dl_sum;
    assign dl_sum = {1'b0, t_ext} + (DW + 1)'(task_deadline_reg[k_idx]);

    // selection compare of scanned slot against best so far
    logic earlier;
    always_comb
    begin
        if (job_dl_reg[i_idx] != best_dl_reg)
            earlier = job_dl_reg[i_idx] < best_dl_reg;
        else if (job_rel_reg[i_idx] != best_rel_reg)
            earlier = job_rel_reg[i_idx] < best_rel_reg;
        else
            earlier = job_task_reg[i_idx] < best_task_reg;
    end

    logic [3:0] charge;
    logic [8:0] sum_add;
    assign charge  = (job_left_reg[i_idx] < task_exec_reg[job_task_reg[i_idx]])
                     ? stack_started_reg : stack_waiting_reg;
    assign sum_add = {1'b0, sum_reg} + 9'(charge);

    logic [DW-1:0] tick_ext;
    logic [2:0]    run_task;
    logic [7:0]    worst_next;
    assign tick_ext   = DW'(time_reg);
    assign run_task   = found_reg ? 3'(job_task_reg[sel_reg]) : 3'd0;
    assign worst_next = (found_reg && sum_reg > worst_reg) ? sum_reg : worst_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    // result register takes the finished tick when empty or being drained
    logic fin_fire;
    assign fin_fire = (state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            num_tasks_reg     <= 4'd0;
            stack_started_reg <= STACK_STARTED_RST;
            stack_waiting_reg <= STACK_WAITING_RST;
            job_valid_reg     <= '0;
            time_reg          <= '0;
            worst_reg         <= 8'd0;
            m_valid_reg       <= 1'b0;
            for (int t = 0; t < MAX_TASKS; t++)
            begin
                task_phase_reg[t]    <= 16'd0;
                task_period_reg[t]   <= 16'd1;
                task_deadline_reg[t] <= 16'd0;
                task_exec_reg[t]     <= 16'd1;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_NUM_TASKS:     num_tasks_reg     <= pwdata[3:0];
                    REG_STACK_STARTED: stack_started_reg <= pwdata[3:0];
                    REG_STACK_WAITING: stack_waiting_reg <= pwdata[3:0];
                    default:           ;
                endcase
            end
            if (fin_fire)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        case (command)
                            CMD_LOAD:
                            begin
                                if (32'(task_index) < MAX_TASKS)
                                begin
                                    task_phase_reg[TW'(task_index)]    <= release_offset;
                                    task_period_reg[TW'(task_index)]   <=
                                        (release_period == 16'd0) ? 16'd1 : release_period;
                                    task_deadline_reg[TW'(task_index)] <= relative_deadline;
                                    task_exec_reg[TW'(task_index)]     <=
                                        (exec_ticks == 16'd0) ? 16'd1 : exec_ticks;
                                end
                            end
                            CMD_TICK:
                            begin
                                k_reg     <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= ST_REL;
                            end
                            CMD_CLEAR:
                            begin
                                job_valid_reg <= '0;
                                time_reg      <= '0;
                                worst_reg     <= 8'd0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_REL:
                begin
                    if (k_reg < n_eff)
                    begin
                        dvd_reg   <= phase_gap;
                        rem_reg   <= 16'd0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SEL;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_new;
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DW - 1))
                    begin
                        if (rem_new == 16'd0)
                        begin
                            if (!free_any)
                                ovf_reg <= 1'b1;
                            else
                            begin
                                job_valid_reg[free_idx] <= 1'b1;
                                job_task_reg[free_idx]  <= k_idx;
                                job_dl_reg[free_idx]    <= dl_sum[TIME_BITS:0];
                                job_rel_reg[free_idx]   <= time_reg;
                                job_left_reg[free_idx]  <= task_exec_reg[k_idx];
                            end
                        end
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_REL;
                    end
                end
                ST_SEL:
                begin
                    if (job_valid_reg[i_idx] && (!found_reg || earlier))
                    begin
                        found_reg     <= 1'b1;
                        sel_reg       <= i_idx;
                        best_dl_reg   <= job_dl_reg[i_idx];
                        best_rel_reg  <= job_rel_reg[i_idx];
                        best_task_reg <= job_task_reg[i_idx];
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == IW'(JOB_SLOTS - 1))
                        state_reg <= ST_DEC;
                end
                ST_DEC:
                begin
                    sum_reg <= 8'd0;
                    i_reg   <= '0;
                    if (found_reg)
                    begin
                        job_left_reg[sel_reg] <= job_left_reg[sel_reg] - 16'd1;
                        state_reg <= ST_SUM;
                    end
                    else
                        state_reg <= ST_FIN;
                end
                ST_SUM:
                begin
                    if (job_valid_reg[i_idx])
                        sum_reg <= sum_add[8] ? 8'hFF : sum_add[7:0];
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == IW'(JOB_SLOTS - 1))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        worst_reg <= worst_next;
                        if (found_reg && job_left_reg[sel_reg] == 16'd0)
                            job_valid_reg[sel_reg] <= 1'b0;
                        m_data_reg  <= {3'd0, ovf_reg, worst_next, sum_reg, run_task,
                                        !found_reg, tick_ext[15:0]};
                        time_reg    <= time_reg + 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a tick keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TICK) |=> !s_axis_tready)
        else $error("tick accepted without going busy");

    // an idle result carries no task and no stack use
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |->
            (m_axis_tdata[19:17] == 3'd0 && m_axis_tdata[27:20] == 8'd0))
        else $error("idle result with task or stack");

    // worst value never below the current sum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[35:28] >= m_axis_tdata[27:20]))
        else $error("stack_worst below stack_now");

endmodule

// File: tb/edf_tick_scheduler_tb.sv
// Self-checking testbench for the EDF tick scheduler: stream stimulus, APB setup, predictor.
module edf_tick_scheduler_tb;
    import edf_pkg::*;

    localparam int NTASK = 8;
    localparam int NSLOT = 16;
    localparam int TICK_CYCLES = 4 + 2 * NSLOT + NTASK * 17;
    localparam int RANDOM_ITEMS = 1625;

    // first member in the highest bits, so tick_time lands at [15:0]
    typedef struct packed {
        logic        slot_overflow;
        logic [7:0]  stack_worst;
        logic [7:0]  stack_now;
        logic [2:0]  running_task;
        logic        idle;
        logic [15:0] tick_time;
    } sched_out_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cmd;
        logic [2:0]  idx;
        logic [15:0] off;
        logic [15:0] per;
        logic [15:0] dl;
        logic [15:0] ex;
        bit          has_exp;
        sched_out_t  exp_out;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // task_index[2:0], release_offset[18:3], release_period[34:19],
    // relative_deadline[50:35], exec_ticks[66:51], zero fill
    logic [71:0] s_axis_tdata;
    // command[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tick_time[15:0], idle[16], running_task[19:17], stack_now[27:20],
    // stack_worst[35:28], slot_overflow[36], zero fill
    logic [39:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [15:0] tk_phase [NTASK];
    logic [15:0] tk_period [NTASK];
    logic [15:0] tk_deadline [NTASK];
    logic [15:0] tk_exec [NTASK];
    bit          jb_valid [NSLOT];
    logic [2:0]  jb_task [NSLOT];
    logic [16:0] jb_abs_dl [NSLOT];
    logic [15:0] jb_rel_time [NSLOT];
    logic [15:0] jb_left [NSLOT];
    logic [15:0] now_time;
    logic [7:0]  worst_seen;
    logic [3:0]  cfg_num_tasks;
    logic [3:0]  cfg_started;
    logic [3:0]  cfg_waiting;

    sched_out_t  tick_results_due[$];
    int          n_errors;
    int          n_ticks_checked;
    int          n_overflows;
    int          n_idle;
    bit          rx_no_stall;
    bit          tx_no_gap;

    edf_tick_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 4_000_000);
        $display("edf_tick_scheduler_tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Applies one accepted transaction to the predictor state.
    task automatic schedule_step(input logic [1:0] cmd, input logic [2:0] idx,
                                 input logic [15:0] off, input logic [15:0] per,
                                 input logic [15:0] dl, input logic [15:0] ex,
                                 output bit has_out, output sched_out_t res);
        int          n;
        int          s;
        int          sel;
        bit          found;
        bit          ovf;
        int          sum;
        logic [15:0] t;
        has_out = 0;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            tk_phase[idx] = off;
            tk_period[idx] = (per == 0) ? 16'd1 : per;
            tk_deadline[idx] = dl;
            tk_exec[idx] = (ex == 0) ? 16'd1 : ex;
        end
        else if (cmd == CMD_CLEAR)
        begin
            foreach (jb_valid[k])
                jb_valid[k] = 0;
            now_time = '0;
            worst_seen = '0;
        end
        else if (cmd == CMD_TICK)
        begin
            t = now_time;
            ovf = 0;
            found = 0;
            sel = 0;
            sum = 0;
            n = (cfg_num_tasks > NTASK) ? NTASK : cfg_num_tasks;
            for (int i = 0; i < n; i++)
            begin
                if (t % tk_period[i] == tk_phase[i] % tk_period[i])
                begin
                    s = 0;
                    while (s < NSLOT && jb_valid[s])
                        s++;
                    if (s >= NSLOT)
                        ovf = 1;
                    else
                    begin
                        jb_valid[s] = 1;
                        jb_task[s] = i[2:0];
                        jb_abs_dl[s] = {1'b0, t} + {1'b0, tk_deadline[i]};
                        jb_rel_time[s] = t;
                        jb_left[s] = tk_exec[i];
                    end
                end
            end
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!jb_valid[i])
                    continue;
                if (!found || jb_abs_dl[i] < jb_abs_dl[sel]
                    || (jb_abs_dl[i] == jb_abs_dl[sel] && jb_rel_time[i] < jb_rel_time[sel])
                    || (jb_abs_dl[i] == jb_abs_dl[sel] && jb_rel_time[i] == jb_rel_time[sel]
                        && jb_task[i] < jb_task[sel]))
                begin
                    sel = i;
                    found = 1;
                end
            end
            if (found)
            begin
                jb_left[sel] = jb_left[sel] - 1;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!jb_valid[i])
                        continue;
                    sum += (jb_left[i] < tk_exec[jb_task[i]]) ? cfg_started : cfg_waiting;
                    if (sum > 255)
                        sum = 255;
                end
                if (sum > worst_seen)
                    worst_seen = sum[7:0];
                if (jb_left[sel] == 0)
                    jb_valid[sel] = 0;
            end
            res.tick_time = t;
            res.idle = !found;
            res.running_task = found ? jb_task[sel] : 3'd0;
            res.stack_now = sum[7:0];
            res.stack_worst = worst_seen;
            res.slot_overflow = ovf;
            has_out = 1;
            now_time = t + 16'd1;
        end
    endtask

    task automatic send_item(input stim_row_t row);
        int         gap;
        bit         has_out;
        sched_out_t res;
        gap = tx_no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser = row.cmd;
        s_axis_tdata = {5'd0, row.ex, row.dl, row.per, row.off, row.idx};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        schedule_step(row.cmd, row.idx, row.off, row.per, row.dl, row.ex, has_out, res);
        if (has_out)
            tick_results_due.push_back(row.has_exp ? row.exp_out : res);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] regno, input logic [3:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {regno, 2'b00};
        pwdata = {28'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (regno)
            REG_NUM_TASKS:     cfg_num_tasks = value;
            REG_STACK_STARTED: cfg_started = value;
            REG_STACK_WAITING: cfg_waiting = value;
            default: ;
        endcase
    endtask

    // Block is idle once every tick result is out and a full tick time has passed.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (tick_results_due.size() != 0)
            @(negedge clk);
        repeat (TICK_CYCLES + 20) @(negedge clk);
    endtask

    function automatic stim_row_t mk(input logic [1:0] cmd, input logic [2:0] idx,
                                     input logic [15:0] off, input logic [15:0] per,
                                     input logic [15:0] dl, input logic [15:0] ex);
        stim_row_t r;
        r.is_cfg = 0;
        r.cmd = cmd;
        r.idx = idx;
        r.off = off;
        r.per = per;
        r.dl = dl;
        r.ex = ex;
        r.has_exp = 0;
        r.exp_out = '0;
        return r;
    endfunction

    function automatic stim_row_t mk_cfg(input logic [1:0] regno, input logic [3:0] value);
        stim_row_t r;
        r = mk(2'd0, 3'd0, {12'd0, value}, 16'd0, 16'd0, 16'd0);
        r.is_cfg = 1;
        r.idx = {1'b0, regno};
        return r;
    endfunction

    function automatic stim_row_t mk_tick_exp(input sched_out_t e);
        stim_row_t r;
        r = mk(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        r.has_exp = 1;
        r.exp_out = e;
        return r;
    endfunction

    function automatic stim_row_t mk_rand(input logic [1:0] cmd);
        return mk(cmd, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endfunction

    function automatic stim_row_t random_load(input bit wide);
        stim_row_t r;
        if (wide)
            r = mk(CMD_LOAD, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
        else
            r = mk(CMD_LOAD, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(1, 12)), 16'($urandom_range(0, 24)),
                   16'($urandom_range(1, 4)));
        return r;
    endfunction

    // receive side: random stalls, with stretches of none
    initial
    begin
        m_axis_tready = 1'b0;
        rx_no_stall = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_no_stall = !rx_no_stall;
            if (rx_no_stall)
                m_axis_tready = 1'b1;
            else if ($urandom_range(0, 99) < 3)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge clk);
            end
            else
                m_axis_tready = ($urandom_range(0, 99) < 65);
        end
    end

    always @(posedge clk)
    begin
        sched_out_t got;
        sched_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[36:0];
            if (tick_results_due.size() == 0)
            begin
                $error("result with none expected: %h", m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = tick_results_due.pop_front();
                n_ticks_checked++;
                if (want.slot_overflow)
                    n_overflows++;
                if (want.idle)
                    n_idle++;
                if (got.tick_time !== want.tick_time)
                begin
                    $error("tick_time exp %0d got %0d", want.tick_time, got.tick_time);
                    n_errors++;
                end
                if (got.idle !== want.idle)
                begin
                    $error("idle exp %0d got %0d", want.idle, got.idle);
                    n_errors++;
                end
                if (got.running_task !== want.running_task)
                begin
                    $error("running_task exp %0d got %0d", want.running_task, got.running_task);
                    n_errors++;
                end
                if (got.stack_now !== want.stack_now)
                begin
                    $error("stack_now exp %0d got %0d", want.stack_now, got.stack_now);
                    n_errors++;
                end
                if (got.stack_worst !== want.stack_worst)
                begin
                    $error("stack_worst exp %0d got %0d", want.stack_worst, got.stack_worst);
                    n_errors++;
                end
                if (got.slot_overflow !== want.slot_overflow)
                begin
                    $error("slot_overflow exp %0d got %0d", want.slot_overflow,
                           got.slot_overflow);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t directed[$];
        stim_row_t row;
        sched_out_t e;
        int        r;
        int        sent;
        int        waited;

        n_errors = 0;
        n_ticks_checked = 0;
        n_overflows = 0;
        n_idle = 0;
        tx_no_gap = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_LOAD;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < NTASK; i++)
        begin
            tk_phase[i] = 0;
            tk_period[i] = 1;
            tk_deadline[i] = 0;
            tk_exec[i] = 1;
        end
        foreach (jb_valid[k])
            jb_valid[k] = 0;
        now_time = 0;
        worst_seen = 0;
        cfg_num_tasks = 0;
        cfg_started = STACK_STARTED_RST;
        cfg_waiting = STACK_WAITING_RST;

        // after reset: no tasks enabled, so an idle tick at time 0
        e = '0;
        e.idle = 1'b1;
        directed.push_back(mk_tick_exp(e));
        directed.push_back(mk(2'd3, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        e.tick_time = 16'd1;
        directed.push_back(mk_tick_exp(e));
        // zero period and exec stored as one; all-ones fields
        directed.push_back(mk(CMD_LOAD, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.push_back(mk(CMD_LOAD, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        directed.push_back(mk(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // tasks 0..6 release every tick, 1..6 with long jobs: table fills, then overflows
        directed.push_back(mk_cfg(REG_NUM_TASKS, 4'd8));
        directed.push_back(mk_cfg(REG_STACK_STARTED, 4'd15));
        directed.push_back(mk_cfg(REG_STACK_WAITING, 4'd0));
        for (int i = 1; i < 7; i++)
            directed.push_back(mk(CMD_LOAD, i[2:0], 16'd0, 16'd1, 16'(9 - i), 16'd500));
        directed.push_back(mk(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.push_back(mk(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.push_back(mk(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.push_back(mk(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // count above table size; release before phase (phase 5 period 3 fires at time 2)
        directed.push_back(mk_cfg(REG_NUM_TASKS, 4'd15));
        directed.push_back(mk_cfg(REG_STACK_WAITING, 4'd15));
        for (int i = 0; i < NTASK; i++)
            directed.push_back(mk(CMD_LOAD, i[2:0], 16'(5 + i), 16'd3, 16'd4, 16'd2));
        repeat (4)
            directed.push_back(mk(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));

        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_idle();
                apb_write(directed[i].idx[1:0], directed[i].off[3:0]);
            end
            else
                send_item(directed[i]);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // new phase: idle, then a fresh register setting, extremes now and then
            wait_idle();
            r = $urandom_range(0, 5);
            apb_write(REG_NUM_TASKS, (r == 0) ? 4'd0 : (r == 1) ? 4'd15
                                     : 4'($urandom_range(1, 8)));
            r = $urandom_range(0, 5);
            apb_write(REG_STACK_STARTED, (r == 0) ? 4'd0 : (r == 1) ? 4'd15
                                         : 4'($urandom_range(0, 15)));
            r = $urandom_range(0, 5);
            apb_write(REG_STACK_WAITING, (r == 0) ? 4'd0 : (r == 1) ? 4'd15
                                         : 4'($urandom_range(0, 15)));
            tx_no_gap = ($urandom_range(0, 3) == 0);
            send_item(mk(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
            for (int i = 0; i < NTASK; i++)
            begin
                row = random_load($urandom_range(0, 9) == 0);
                row.idx = i[2:0];
                send_item(row);
                sent++;
            end
            repeat ($urandom_range(120, 220))
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    row = mk_rand(CMD_TICK);
                else if (r < 93)
                    row = random_load($urandom_range(0, 4) == 0);
                else if (r < 96)
                    row = mk_rand(CMD_CLEAR);
                else
                    row = mk_rand(2'd3);
                send_item(row);
                if (row.cmd != 2'd3)
                    sent++;
            end
        end

        s_axis_tvalid = 1'b0;
        waited = 0;
        while (tick_results_due.size() != 0 && waited < 200_000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TICK_CYCLES + 50) @(negedge clk);

        $display("covered %0d tick results (%0d idle, %0d with slot overflow)",
                 n_ticks_checked, n_idle, n_overflows);
        $display("register phases with num_tasks 0..15 and stack weights 0..15");
        if (n_errors == 0 && tick_results_due.size() == 0)
            $display("edf_tick_scheduler_tb OK");
        else
        begin
            if (tick_results_due.size() != 0)
                $error("%0d tick results never arrived", tick_results_due.size());
            $display("edf_tick_scheduler_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
design/edf_pkg.sv
design/edf_tick_scheduler.sv
tb/edf_tick_scheduler_tb.sv
